>>> rtl/ffbs_pkg.sv
// Package for the first-fit block sub-allocator.
// Holds the sizes, command and status codes, and the state and record types.
// No dependencies.
package ffbs_pkg;

   localparam int BLOCK_ORDER = 26;
   localparam int NUM_BLOCKS  = 8;
   localparam int NUM_ENTRIES = 64;
   localparam int NUM_KINDS   = 4;

   localparam int ENTRY_AW = 6;
   localparam int BLOCK_AW = 3;
   localparam int SCAN_W   = ENTRY_AW + 1;
   localparam int POS_W    = 26;
   localparam int LEN_W    = 27;
   localparam int KIND_W   = 2;

   localparam logic [LEN_W-1:0]    BLOCK_BYTES = LEN_W'(1) << BLOCK_ORDER;
   localparam logic [SCAN_W-1:0]   SCAN_END    = SCAN_W'(NUM_ENTRIES);
   localparam logic [BLOCK_AW-1:0] RANK_LAST   = BLOCK_AW'(NUM_BLOCKS - 1);

   typedef enum logic [1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_QUERY = 2'd2,
      CMD_RSVD  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      STS_OK         = 3'd0,
      STS_BAD_SIZE   = 3'd1,
      STS_NO_BLOCK   = 3'd2,
      STS_NO_ENTRY   = 3'd3,
      STS_BAD_HANDLE = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_PICK,
      ST_SCAN,
      ST_EVAL,
      ST_CLAIM,
      ST_PLACE,
      ST_HREAD,
      ST_HDONE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [BLOCK_AW-1:0] blk;
      logic [POS_W-1:0]    pos;
      logic [LEN_W-1:0]    len;
   } entry_type;

   typedef struct packed {
      logic [LEN_W-1:0]    size;
      logic [POS_W-1:0]    pos;
      logic [BLOCK_AW-1:0] blk;
      logic [ENTRY_AW-1:0] handle;
      status_type          status;
   } rsp_type;

endpackage

>>> rtl/ffbs_entry_ram.sv
// Segment table storage: one write port, one read port, registered read data.
// Depends on ffbs_pkg.
module ffbs_entry_ram
   import ffbs_pkg::*;
(
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ENTRY_AW-1:0] wr_addr,
   input  entry_type           wr_data,
   input  logic [ENTRY_AW-1:0] rd_addr,
   output entry_type           rd_data
);

   entry_type entry_mem_ff [NUM_ENTRIES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/first_fit_block_suballocator_unit.sv
// First-fit block sub-allocator, top level.
// A block takes one transaction at a time. Free and query go through the
// decode, handle-read and handle-done states, then the response handoff. An
// allocate walks the claimed blocks of its kind, newest first; each block is
// searched by sweeping the 64-entry segment table once per segment passed,
// plus one final sweep, through the single read port of the segment table.
// Depends on ffbs_pkg and ffbs_entry_ram.
module first_fit_block_suballocator_unit
   import ffbs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // size[26:0], kind[28:27], handle[34:29], zero pad
   input  logic [1:0]  req_tuser,  // command[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata   // status[2:0], out_handle[8:3], block_index[11:9],
                                   // position[37:12], out_size[64:38], zero pad
);

   state_type state_ff, state_in;

   cmd_type             cmd_ff, cmd_in;
   logic [LEN_W-1:0]    size_ff, size_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [ENTRY_AW-1:0] hnd_ff, hnd_in;
   logic [ENTRY_AW-1:0] ne_ff, ne_in;
   logic [BLOCK_AW-1:0] rank_ff, rank_in;
   logic [BLOCK_AW-1:0] blk_ff, blk_in;
   logic [LEN_W-1:0]    cursor_ff, cursor_in;
   logic [SCAN_W-1:0]   scan_cnt_ff, scan_cnt_in;
   logic                any_ff, any_in;
   logic [POS_W-1:0]    best_ff, best_in;
   logic [LEN_W-1:0]    best_len_ff, best_len_in;
   logic [POS_W-1:0]    place_pos_ff, place_pos_in;
   rsp_type             res_ff, res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic [NUM_ENTRIES-1:0] entry_valid_ff, entry_valid_in;
   logic [NUM_BLOCKS-1:0]  block_use_ff, block_use_in;
   logic [KIND_W-1:0]      block_kind_ff [NUM_BLOCKS];
   logic [KIND_W-1:0]      block_kind_in [NUM_BLOCKS];
   logic [LEN_W-1:0]       block_free_ff [NUM_BLOCKS];
   logic [LEN_W-1:0]       block_free_in [NUM_BLOCKS];
   logic [BLOCK_AW-1:0]    block_rank_ff [NUM_BLOCKS];
   logic [BLOCK_AW-1:0]    block_rank_in [NUM_BLOCKS];

   logic                req_fire;
   logic                slot_free;
   logic                bad_req;
   logic                free_hit;
   logic [ENTRY_AW-1:0] free_idx;
   logic                pick_hit;
   logic [BLOCK_AW-1:0] pick_blk;
   logic                claim_hit;
   logic [BLOCK_AW-1:0] claim_blk;
   logic                rank_last;
   logic [ENTRY_AW-1:0] prev_idx;
   logic                scan_live;
   logic                scan_hit;
   logic                fit;
   logic [LEN_W-1:0]    next_cursor;
   logic [LEN_W-1:0]    best_ext;
   logic                hnd_valid;

   logic                ram_wr_en;
   logic [ENTRY_AW-1:0] ram_wr_addr;
   entry_type           ram_wr_data;
   logic [ENTRY_AW-1:0] ram_rd_addr;
   entry_type           ram_rd_data;

   ffbs_entry_ram u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_data_ff};

   assign bad_req = (size_ff == '0) || (size_ff > BLOCK_BYTES) ||
                    ({1'b0, kind_ff} >= 3'(NUM_KINDS));
   assign rank_last = (rank_ff == RANK_LAST);
   assign hnd_valid = entry_valid_ff[hnd_ff];

   always_comb begin
      free_hit = 1'b0;
      free_idx = '0;
      for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
         if (!entry_valid_ff[i]) begin
            free_hit = 1'b1;
            free_idx = ENTRY_AW'(i);
         end
      end
   end

   always_comb begin
      pick_hit  = 1'b0;
      pick_blk  = '0;
      claim_hit = 1'b0;
      claim_blk = '0;
      for (int b = NUM_BLOCKS - 1; b >= 0; b--) begin
         if (block_use_ff[b] && block_rank_ff[b] == rank_ff &&
             block_kind_ff[b] == kind_ff && size_ff <= block_free_ff[b]) begin
            pick_hit = 1'b1;
            pick_blk = BLOCK_AW'(b);
         end
         if (!block_use_ff[b]) begin
            claim_hit = 1'b1;
            claim_blk = BLOCK_AW'(b);
         end
      end
   end

   // read data is registered, so it belongs to the previous sweep count
   assign prev_idx  = ENTRY_AW'(scan_cnt_ff - SCAN_W'(1));
   assign scan_live = (state_ff == ST_SCAN) && (scan_cnt_ff != '0);
   assign scan_hit  = scan_live && entry_valid_ff[prev_idx] &&
                      ram_rd_data.blk == blk_ff &&
                      {1'b0, ram_rd_data.pos} >= cursor_ff &&
                      (!any_ff || ram_rd_data.pos < best_ff);

   assign best_ext    = {1'b0, best_ff};
   assign next_cursor = best_ext + best_len_ff;
   assign fit = any_ff ? ((best_ext - cursor_ff) >= size_ff)
                       : ((cursor_ff <= BLOCK_BYTES) &&
                          ((BLOCK_BYTES - cursor_ff) >= size_ff));

   assign ram_rd_addr = (state_ff == ST_SCAN) ? scan_cnt_ff[ENTRY_AW-1:0] : hnd_ff;
   assign ram_wr_en   = (state_ff == ST_PLACE);
   assign ram_wr_addr = ne_ff;
   assign ram_wr_data = '{blk: blk_ff, pos: place_pos_ff, len: size_ff};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            unique case (cmd_ff)
               CMD_ALLOC: state_in = (bad_req || !free_hit) ? ST_RESP : ST_PICK;
               CMD_FREE, CMD_QUERY: state_in = hnd_valid ? ST_HREAD : ST_RESP;
               default: state_in = ST_RESP;
            endcase
         end
         ST_PICK: begin
            priority if (pick_hit) state_in = ST_SCAN;
            else if (rank_last)    state_in = ST_CLAIM;
            else                   state_in = ST_PICK;
         end
         ST_SCAN: begin
            if (scan_cnt_ff == SCAN_END) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            priority if (fit) state_in = ST_PLACE;
            else if (any_ff)  state_in = ST_SCAN;
            else if (rank_last) state_in = ST_CLAIM;
            else              state_in = ST_PICK;
         end
         ST_CLAIM: state_in = claim_hit ? ST_PLACE : ST_RESP;
         ST_PLACE: state_in = ST_RESP;
         ST_HREAD: state_in = ST_HDONE;
         ST_HDONE: state_in = ST_RESP;
         ST_RESP: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd_in         = cmd_ff;
      size_in        = size_ff;
      kind_in        = kind_ff;
      hnd_in         = hnd_ff;
      ne_in          = ne_ff;
      rank_in        = rank_ff;
      blk_in         = blk_ff;
      cursor_in      = cursor_ff;
      scan_cnt_in    = scan_cnt_ff;
      any_in         = any_ff;
      best_in        = best_ff;
      best_len_in    = best_len_ff;
      place_pos_in   = place_pos_ff;
      res_in         = res_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      entry_valid_in = entry_valid_ff;
      block_use_in   = block_use_ff;
      block_kind_in  = block_kind_ff;
      block_free_in  = block_free_ff;
      block_rank_in  = block_rank_ff;

      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in  = cmd_type'(req_tuser);
               size_in = req_tdata[26:0];
               kind_in = req_tdata[28:27];
               hnd_in  = req_tdata[34:29];
            end
         end
         ST_DECODE: begin
            res_in = '0;
            unique case (cmd_ff)
               CMD_ALLOC: begin
                  priority if (bad_req) res_in.status = STS_BAD_SIZE;
                  else if (!free_hit)   res_in.status = STS_NO_ENTRY;
                  else begin
                     ne_in   = free_idx;
                     rank_in = '0;
                  end
               end
               CMD_FREE, CMD_QUERY: begin
                  res_in.status = STS_BAD_HANDLE;
                  res_in.handle = hnd_ff;
               end
               default: res_in.status = STS_BAD_HANDLE;
            endcase
         end
         ST_PICK: begin
            if (pick_hit) begin
               blk_in      = pick_blk;
               cursor_in   = '0;
               scan_cnt_in = '0;
               any_in      = 1'b0;
            end else begin
               rank_in = rank_ff + BLOCK_AW'(1);
            end
         end
         ST_SCAN: begin
            if (scan_cnt_ff != SCAN_END) scan_cnt_in = scan_cnt_ff + SCAN_W'(1);
            if (scan_hit) begin
               any_in      = 1'b1;
               best_in     = ram_rd_data.pos;
               best_len_in = ram_rd_data.len;
            end
         end
         ST_EVAL: begin
            priority if (fit) begin
               place_pos_in = cursor_ff[POS_W-1:0];
            end else if (any_ff) begin
               cursor_in   = next_cursor;
               scan_cnt_in = '0;
               any_in      = 1'b0;
            end else begin
               rank_in = rank_ff + BLOCK_AW'(1);
            end
         end
         ST_CLAIM: begin
            if (claim_hit) begin
               for (int b = 0; b < NUM_BLOCKS; b++) begin
                  if (block_use_ff[b]) block_rank_in[b] = block_rank_ff[b] + BLOCK_AW'(1);
               end
               block_use_in[claim_blk]  = 1'b1;
               block_kind_in[claim_blk] = kind_ff;
               block_free_in[claim_blk] = BLOCK_BYTES;
               block_rank_in[claim_blk] = '0;
               blk_in       = claim_blk;
               place_pos_in = '0;
            end else begin
               res_in.status = STS_NO_BLOCK;
            end
         end
         ST_PLACE: begin
            entry_valid_in[ne_ff] = 1'b1;
            block_free_in[blk_ff] = block_free_ff[blk_ff] - size_ff;
            res_in = '{size: size_ff, pos: place_pos_ff, blk: blk_ff,
                       handle: ne_ff, status: STS_OK};
         end
         ST_HREAD: ;
         ST_HDONE: begin
            res_in = '{size: ram_rd_data.len, pos: ram_rd_data.pos,
                       blk: ram_rd_data.blk, handle: hnd_ff, status: STS_OK};
            if (cmd_ff == CMD_FREE) begin
               entry_valid_in[hnd_ff] = 1'b0;
               block_free_in[ram_rd_data.blk] =
                  block_free_ff[ram_rd_data.blk] + ram_rd_data.len;
            end
         end
         ST_RESP: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         entry_valid_ff <= '0;
         block_use_ff   <= '0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         entry_valid_ff <= entry_valid_in;
         block_use_ff   <= block_use_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      size_ff       <= size_in;
      kind_ff       <= kind_in;
      hnd_ff        <= hnd_in;
      ne_ff         <= ne_in;
      rank_ff       <= rank_in;
      blk_ff        <= blk_in;
      cursor_ff     <= cursor_in;
      scan_cnt_ff   <= scan_cnt_in;
      any_ff        <= any_in;
      best_ff       <= best_in;
      best_len_ff   <= best_len_in;
      place_pos_ff  <= place_pos_in;
      res_ff        <= res_in;
      rsp_data_ff   <= rsp_data_in;
      block_kind_ff <= block_kind_in;
      block_free_ff <= block_free_in;
      block_rank_ff <= block_rank_in;
   end

endmodule

>>> rtl/ffbs_checker.sv
// Port-level checks for the sub-allocator, bound to the top level.
// Depends on first_fit_block_suballocator_unit.
module ffbs_port_props (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response transaction changed");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

   a_bad_size_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] == 3'd1 |-> rsp_tdata[71:3] == '0)
      else $error("bad size response carries data");

   a_ok_size: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] == 3'd0 |-> rsp_tdata[64:38] != '0)
      else $error("ok response with zero size");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind first_fit_block_suballocator_unit ffbs_port_props u_ffbs_port_props (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
